// ===== rtl/greedy_box_suppression_top_assert.svh =====
// Assertion macros used by the box suppression top level.
`ifndef GREEDY_BOX_SUPPRESSION_TOP_ASSERT_SVH
`define GREEDY_BOX_SUPPRESSION_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define GBS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("box suppression assertion failed");

// The consequent holds in the cycle after the antecedent.
`define GBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("box suppression assertion failed");

`else

`define GBS_ASSERT_SAME(label, clk, rst, ante, cons)
`define GBS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/gbs_pkg.sv =====
// Types, widths and constants of the box suppression block.
package gbs_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int CLASS_WIDTH = 4;
   localparam int THR_WIDTH   = 16;
   localparam logic [THR_WIDTH-1:0] THR_RESET = 16'd29491;

   // Corner coordinates at twice the scale, signed.
   localparam int CORNER_WIDTH = COORD_WIDTH + 3;
   // Overlap span at twice the scale never exceeds twice the smaller size.
   localparam int SPAN_WIDTH   = COORD_WIDTH + 1;
   localparam int AREA_WIDTH   = 2 * SPAN_WIDTH;
   localparam int SUM_WIDTH    = AREA_WIDTH + 1;
   localparam int PROD_WIDTH   = SUM_WIDTH + THR_WIDTH;
   localparam int CENTER_WORD  = 2 * COORD_WIDTH;
   localparam int SIZE_WORD    = 2 * COORD_WIDTH + CLASS_WIDTH;

   typedef struct packed {
      logic [CLASS_WIDTH-1:0] class_id;
      logic [COORD_WIDTH-1:0] center_x;
      logic [COORD_WIDTH-1:0] center_y;
      logic [COORD_WIDTH-1:0] box_width;
      logic [COORD_WIDTH-1:0] box_height;
   } box_type;

   typedef struct packed {
      logic busy;
      logic hit_valid;
      logic hit;
   } iou_status_type;

   typedef struct packed {
      logic                   kept;
      logic [CLASS_WIDTH-1:0] out_class;
      logic [COORD_WIDTH-1:0] out_center_x;
      logic [COORD_WIDTH-1:0] out_center_y;
      logic                   store_overflow;
   } result_type;

endpackage

// ===== rtl/gbs_req_if.sv =====
// Channel interfaces for boxes, results and the threshold register.
interface gbs_req_if;
   import gbs_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   start_frame;
   logic [CLASS_WIDTH-1:0] class_id;
   logic [COORD_WIDTH-1:0] center_x;
   logic [COORD_WIDTH-1:0] center_y;
   logic [COORD_WIDTH-1:0] box_width;
   logic [COORD_WIDTH-1:0] box_height;
   modport source (output valid, start_frame, class_id, center_x, center_y, box_width,
                   box_height, input ready);
   modport sink (input valid, start_frame, class_id, center_x, center_y, box_width,
                 box_height, output ready);
endinterface

interface gbs_rsp_if;
   import gbs_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   kept;
   logic [CLASS_WIDTH-1:0] out_class;
   logic [COORD_WIDTH-1:0] out_center_x;
   logic [COORD_WIDTH-1:0] out_center_y;
   logic                   store_overflow;
   modport source (output valid, kept, out_class, out_center_x, out_center_y,
                   store_overflow, input ready);
   modport sink (input valid, kept, out_class, out_center_x, out_center_y,
                 store_overflow, output ready);
endinterface

interface gbs_csr_if;
   import gbs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [THR_WIDTH-1:0] iou_threshold;
   modport source (output valid, iou_threshold, input ready);
   modport sink (input valid, iou_threshold, output ready);
endinterface

// ===== rtl/gbs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module gbs_ram #(
   parameter int WIDTH      = 32,
   parameter int DEPTH      = 256,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gbs_iou.sv =====
// Pipelined overlap test of one stored box against the candidate box.
module gbs_iou (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           entry_valid,
   input  gbs_pkg::box_type               entry,
   input  gbs_pkg::box_type               cand,
   input  logic [gbs_pkg::THR_WIDTH-1:0]  threshold,
   output gbs_pkg::iou_status_type        status
);
   import gbs_pkg::*;

   function automatic logic signed [CORNER_WIDTH-1:0] corner(
      input logic [COORD_WIDTH-1:0] c, input logic [COORD_WIDTH-1:0] s, input logic upper);
      logic signed [CORNER_WIDTH-1:0] twice;
      logic signed [CORNER_WIDTH-1:0] size;
      twice = $signed({2'b00, c, 1'b0});
      size  = $signed({3'b000, s});
      return upper ? (twice + size) : (twice - size);
   endfunction

   function automatic logic [SPAN_WIDTH-1:0] span(
      input logic [COORD_WIDTH-1:0] ac, input logic [COORD_WIDTH-1:0] as,
      input logic [COORD_WIDTH-1:0] bc, input logic [COORD_WIDTH-1:0] bs);
      logic signed [CORNER_WIDTH-1:0] a1, a2, b1, b2, lo, hi;
      logic signed [CORNER_WIDTH:0]   d;
      a1 = corner(ac, as, 1'b0);
      a2 = corner(ac, as, 1'b1);
      b1 = corner(bc, bs, 1'b0);
      b2 = corner(bc, bs, 1'b1);
      lo = (a1 > b1) ? a1 : b1;
      hi = (a2 < b2) ? a2 : b2;
      d  = {hi[CORNER_WIDTH-1], hi} - {lo[CORNER_WIDTH-1], lo};
      return (d <= 0) ? '0 : d[SPAN_WIDTH-1:0];
   endfunction

   logic [2*COORD_WIDTH-1:0] cand_area_ff, cand_area_in;

   logic                     va_ff, va_in;
   logic                     match_a_ff, match_a_in;
   logic [SPAN_WIDTH-1:0]    iw_a_ff, iw_a_in, ih_a_ff, ih_a_in;
   logic [2*COORD_WIDTH-1:0] area_a_ff, area_a_in;

   logic                     vb_ff, match_b_ff;
   logic [AREA_WIDTH-1:0]    inter_b_ff, inter_b_in;
   logic [SUM_WIDTH-1:0]     sum_b_ff, sum_b_in;

   logic                     vc_ff, match_c_ff;
   logic [AREA_WIDTH-1:0]    inter_c_ff;
   logic [SUM_WIDTH-1:0]     union_c_ff, union_c_in;

   logic                     vd_ff, match_d_ff;
   logic [AREA_WIDTH-1:0]    inter_d_ff;
   logic [PROD_WIDTH-1:0]    prod_d_ff, prod_d_in;

   always_comb begin
      cand_area_in = (2*COORD_WIDTH)'(cand.box_width) * (2*COORD_WIDTH)'(cand.box_height);
      va_in        = entry_valid;
      match_a_in   = (entry.class_id == cand.class_id);
      iw_a_in      = span(entry.center_x, entry.box_width, cand.center_x, cand.box_width);
      ih_a_in      = span(entry.center_y, entry.box_height, cand.center_y, cand.box_height);
      area_a_in    = (2*COORD_WIDTH)'(entry.box_width) * (2*COORD_WIDTH)'(entry.box_height);
      inter_b_in   = AREA_WIDTH'(iw_a_ff) * AREA_WIDTH'(ih_a_ff);
      sum_b_in     = {1'b0, area_a_ff, 2'b00} + {1'b0, cand_area_ff, 2'b00};
      union_c_in   = sum_b_ff - {1'b0, inter_b_ff};
      prod_d_in    = PROD_WIDTH'(threshold) * PROD_WIDTH'(union_c_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      cand_area_ff <= cand_area_in;
      match_a_ff   <= match_a_in;
      iw_a_ff      <= iw_a_in;
      ih_a_ff      <= ih_a_in;
      area_a_ff    <= area_a_in;
      match_b_ff   <= match_a_ff;
      inter_b_ff   <= inter_b_in;
      sum_b_ff     <= sum_b_in;
      match_c_ff   <= match_b_ff;
      inter_c_ff   <= inter_b_ff;
      union_c_ff   <= union_c_in;
      match_d_ff   <= match_c_ff;
      inter_d_ff   <= inter_c_ff;
      prod_d_ff    <= prod_d_in;
   end

   assign status.busy      = va_ff | vb_ff | vc_ff | vd_ff;
   assign status.hit_valid = vd_ff;
   assign status.hit       = vd_ff & match_d_ff &
                             ({1'b0, inter_d_ff, {THR_WIDTH{1'b0}}} > prod_d_ff);

endmodule

// ===== rtl/greedy_box_suppression_top.sv =====
// Top level of the greedy per-class box suppression block.
//
//   channel   direction   handshake          word
//   req_bus   in          valid / ready      one detection box
//   rsp_bus   out         valid / ready      verdict on that box
//   csr_bus   in          valid / ready      IoU threshold, Q0.16
//
// A box's time from acceptance to result grows with N, the number of boxes kept so far in the
// frame: the single read port of the kept store reads each of the N kept boxes in turn, and the
// read latency and the overlap pipeline add the rest.
// One box is handled at a time; the next is accepted once the current verdict sits
// in the output register. Reset clears the kept count and restores the threshold;
// the store itself needs no clearing. A stalled result holds the block before storing.
`include "greedy_box_suppression_top_assert.svh"

module greedy_box_suppression_top #(
   parameter int MAX_KEPT = 256
) (
   input logic       clock,
   input logic       reset,
   gbs_req_if.sink   req_bus,
   gbs_rsp_if.source rsp_bus,
   gbs_csr_if.sink   csr_bus
);
   import gbs_pkg::*;

   localparam int CW = $clog2(MAX_KEPT + 1);
   localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        scan_ff, scan_in;
   logic                 rd_pending_ff, rd_pending_in;
   logic                 hit_ff, hit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [THR_WIDTH-1:0] thr_ff, thr_in;
   box_type              box_ff, box_in;
   result_type           rsp_ff, rsp_in;

   logic                 accept, rd_en, wr_en, done, keep, room;
   logic [CENTER_WORD-1:0] ctr_rd, ctr_wr;
   logic [SIZE_WORD-1:0]   size_rd, size_wr;
   box_type              entry;
   iou_status_type       status;

   assign accept = req_bus.valid & req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;

   assign keep = ~hit_ff;
   assign room = (count_ff < CW'(MAX_KEPT));
   assign done = (state_ff == S_DRAIN) & ~rd_pending_ff & ~status.busy &
                 (~rsp_valid_ff | rsp_bus.ready);
   assign rd_en = (state_ff == S_SCAN) & (scan_ff != count_ff);
   assign wr_en = done & keep & room;

   assign ctr_wr  = {box_ff.center_y, box_ff.center_x};
   assign size_wr = {box_ff.class_id, box_ff.box_height, box_ff.box_width};

   assign entry.center_x   = ctr_rd[COORD_WIDTH-1:0];
   assign entry.center_y   = ctr_rd[CENTER_WORD-1:COORD_WIDTH];
   assign entry.box_width  = size_rd[COORD_WIDTH-1:0];
   assign entry.box_height = size_rd[CENTER_WORD-1:COORD_WIDTH];
   assign entry.class_id   = size_rd[SIZE_WORD-1:CENTER_WORD];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      rd_pending_in = rd_en;
      hit_in        = hit_ff | (status.hit_valid & status.hit);
      box_in        = box_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_bus.ready;
      thr_in        = (csr_bus.valid & csr_bus.ready) ? csr_bus.iou_threshold : thr_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               box_in.class_id   = req_bus.class_id;
               box_in.center_x   = req_bus.center_x;
               box_in.center_y   = req_bus.center_y;
               box_in.box_width  = req_bus.box_width;
               box_in.box_height = req_bus.box_height;
               if (req_bus.start_frame) begin
                  count_in = '0;
               end
               scan_in  = '0;
               hit_in   = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               scan_in = scan_ff + CW'(1);
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (done) begin
               rsp_in.kept           = keep;
               rsp_in.out_class      = box_ff.class_id;
               rsp_in.out_center_x   = box_ff.center_x;
               rsp_in.out_center_y   = box_ff.center_y;
               rsp_in.store_overflow = keep & ~room;
               rsp_valid_in          = 1'b1;
               if (wr_en) begin
                  count_in = count_ff + CW'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         scan_ff       <= '0;
         rd_pending_ff <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         thr_ff        <= THR_RESET;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         scan_ff       <= scan_in;
         rd_pending_ff <= rd_pending_in;
         hit_ff        <= hit_in;
         rsp_valid_ff  <= rsp_valid_in;
         thr_ff        <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      box_ff <= box_in;
      rsp_ff <= rsp_in;
   end

   gbs_ram #(.WIDTH(CENTER_WORD), .DEPTH(MAX_KEPT), .ADDR_WIDTH(AW)) u_center_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (ctr_wr),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (ctr_rd)
   );

   gbs_ram #(.WIDTH(SIZE_WORD), .DEPTH(MAX_KEPT), .ADDR_WIDTH(AW)) u_size_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (size_wr),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (size_rd)
   );

   gbs_iou u_iou (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (rd_pending_ff),
      .entry       (entry),
      .cand        (box_ff),
      .threshold   (thr_ff),
      .status      (status)
   );

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.kept           = rsp_ff.kept;
   assign rsp_bus.out_class      = rsp_ff.out_class;
   assign rsp_bus.out_center_x   = rsp_ff.out_center_x;
   assign rsp_bus.out_center_y   = rsp_ff.out_center_y;
   assign rsp_bus.store_overflow = rsp_ff.store_overflow;

   `GBS_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_KEPT))
   `GBS_ASSERT_SAME(a_write_quiet, clock, reset, wr_en, !rd_en && !rd_pending_ff && !status.busy)
   `GBS_ASSERT_SAME(a_read_in_range, clock, reset, rd_en, scan_ff < count_ff)
   `GBS_ASSERT_NEXT(a_accept_scans, clock, reset, accept, state_ff == S_SCAN && !hit_ff)
   `GBS_ASSERT_NEXT(a_done_shows, clock, reset, done, rsp_bus.valid && state_ff == S_IDLE)

endmodule

// ===== dv/tb_greedy_box_suppression_top.sv =====
// Self-checking testbench that drives detection boxes and thresholds and checks every verdict.
module tb_greedy_box_suppression_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gbs_pkg::*;

   localparam int STORE_DEPTH  = 256;
   localparam int DRAIN_CYCLES = 16;

   typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_HOLD} ready_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gbs_req_if req_bus();
   gbs_rsp_if rsp_bus();
   gbs_csr_if csr_bus();

   greedy_box_suppression_top #(.MAX_KEPT(STORE_DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   box_type              kept_boxes[STORE_DEPTH];
   int                   kept_count;
   logic [THR_WIDTH-1:0] threshold_q;
   result_type           pending_verdicts[$];

   int mismatches;
   int boxes_judged;
   int frame_starts;
   int n_kept;
   int n_suppressed;
   int n_overflow;
   int thr_writes;
   int burst_left;
   int mode_cycles;
   int hold_left;
   ready_mode_type ready_mode;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [COORD_WIDTH-1:0] clamp_coord(int v);
      if (v < 0) return '0;
      if (v > 65535) return '1;
      return v[COORD_WIDTH-1:0];
   endfunction

   function automatic box_type make_box(int cls, int x, int y, int w, int h);
      box_type b;
      b.class_id   = cls[CLASS_WIDTH-1:0];
      b.center_x   = x[COORD_WIDTH-1:0];
      b.center_y   = y[COORD_WIDTH-1:0];
      b.box_width  = w[COORD_WIDTH-1:0];
      b.box_height = h[COORD_WIDTH-1:0];
      return b;
   endfunction

   function automatic box_type random_box(int unsigned max_size);
      box_type b;
      b.class_id   = CLASS_WIDTH'($urandom);
      b.center_x   = COORD_WIDTH'($urandom);
      b.center_y   = COORD_WIDTH'($urandom);
      b.box_width  = COORD_WIDTH'($urandom_range(0, max_size));
      b.box_height = COORD_WIDTH'($urandom_range(0, max_size));
      return b;
   endfunction

   // Corners are taken at twice the scale, so the areas carry a factor of four.
   function automatic bit overlap_exceeds(box_type a, box_type b, logic [THR_WIDTH-1:0] thr);
      longint ax1, ax2, ay1, ay2, bx1, bx2, by1, by2, iw, ih;
      longint unsigned inter, area_a, area_b, total;
      ax1 = 2 * longint'(a.center_x) - longint'(a.box_width);
      ax2 = 2 * longint'(a.center_x) + longint'(a.box_width);
      ay1 = 2 * longint'(a.center_y) - longint'(a.box_height);
      ay2 = 2 * longint'(a.center_y) + longint'(a.box_height);
      bx1 = 2 * longint'(b.center_x) - longint'(b.box_width);
      bx2 = 2 * longint'(b.center_x) + longint'(b.box_width);
      by1 = 2 * longint'(b.center_y) - longint'(b.box_height);
      by2 = 2 * longint'(b.center_y) + longint'(b.box_height);
      iw = ((ax2 < bx2) ? ax2 : bx2) - ((ax1 > bx1) ? ax1 : bx1);
      ih = ((ay2 < by2) ? ay2 : by2) - ((ay1 > by1) ? ay1 : by1);
      if (iw < 0) iw = 0;
      if (ih < 0) ih = 0;
      inter  = iw * ih;
      area_a = 64'd4 * a.box_width * a.box_height;
      area_b = 64'd4 * b.box_width * b.box_height;
      total  = area_a + area_b - inter;
      return (inter << 16) > (64'(thr) * total);
   endfunction

   function automatic result_type judge_box(bit start, box_type b);
      result_type verdict;
      verdict.kept           = 1'b1;
      verdict.store_overflow = 1'b0;
      if (start) kept_count = 0;
      for (int i = 0; i < kept_count && verdict.kept; i++) begin
         if (kept_boxes[i].class_id == b.class_id &&
             overlap_exceeds(kept_boxes[i], b, threshold_q))
            verdict.kept = 1'b0;
      end
      if (verdict.kept) begin
         if (kept_count < STORE_DEPTH) begin
            kept_boxes[kept_count] = b;
            kept_count++;
         end else begin
            verdict.store_overflow = 1'b1;
         end
      end
      verdict.out_class    = b.class_id;
      verdict.out_center_x = b.center_x;
      verdict.out_center_y = b.center_y;
      return verdict;
   endfunction

   task automatic send_box(bit start, box_type b);
      result_type verdict;
      int gap;
      req_bus.valid       <= 1'b1;
      req_bus.start_frame <= start;
      req_bus.class_id    <= b.class_id;
      req_bus.center_x    <= b.center_x;
      req_bus.center_y    <= b.center_y;
      req_bus.box_width   <= b.box_width;
      req_bus.box_height  <= b.box_height;
      do @(posedge clock); while (!req_bus.ready);
      verdict = judge_box(start, b);
      pending_verdicts.insert(pending_verdicts.size(), verdict);
      boxes_judged++;
      frame_starts += start;
      n_kept       += verdict.kept;
      n_suppressed += !verdict.kept;
      n_overflow   += verdict.store_overflow;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
      end
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(logic [THR_WIDTH-1:0] value);
      wait_idle();
      csr_bus.valid         <= 1'b1;
      csr_bus.iou_threshold <= value;
      do @(posedge clock); while (!csr_bus.ready);
      threshold_q = value;
      thr_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(negedge clock) begin
      if (mode_cycles == 0) begin
         ready_mode  = ready_mode_type'($urandom_range(0, 2));
         mode_cycles = $urandom_range(20, 200);
      end
      mode_cycles--;
      case (ready_mode)
         READY_ALWAYS: rsp_bus.ready <= 1'b1;
         READY_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
         default: begin
            if (hold_left > 0) begin
               rsp_bus.ready <= 1'b0;
               hold_left--;
            end else begin
               rsp_bus.ready <= 1'b1;
               hold_left = $urandom_range(0, 24);
            end
         end
      endcase
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("verdict word arrived with no box pending");
            mismatches++;
         end else begin
            want = pending_verdicts.pop_front();
            check_field("kept", want.kept, rsp_bus.kept);
            check_field("out_class", want.out_class, rsp_bus.out_class);
            check_field("out_center_x", want.out_center_x, rsp_bus.out_center_x);
            check_field("out_center_y", want.out_center_y, rsp_bus.out_center_y);
            check_field("store_overflow", want.store_overflow, rsp_bus.store_overflow);
         end
      end
   end

   task automatic test_default_threshold();
      send_box(1'b1, make_box(0, 0, 0, 0, 0));
      send_box(1'b0, make_box(0, 0, 0, 0, 0));
      send_box(1'b0, make_box(15, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF));
      send_box(1'b0, make_box(15, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF));
      send_box(1'b0, make_box(14, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF));
      send_box(1'b0, make_box(15, 0, 0, 'hFFFF, 'hFFFF));
      send_box(1'b0, make_box(0, 100, 100, 0, 'hFFFF));
   endtask

   task automatic test_threshold_extremes();
      write_threshold('0);
      send_box(1'b1, make_box(3, 1000, 1000, 16, 16));
      send_box(1'b0, make_box(3, 1015, 1000, 16, 16));
      send_box(1'b0, make_box(3, 1016, 1000, 16, 16));
      write_threshold('1);
      send_box(1'b1, make_box(7, 500, 500, 32, 32));
      send_box(1'b0, make_box(7, 500, 500, 32, 32));
      send_box(1'b0, make_box(7, 500, 500, 31, 32));
      send_box(1'b1, make_box(7, 500, 500, 32, 32));
   endtask

   task automatic test_random_frames();
      box_type anchors[4];
      box_type b;
      int phase, left, length, n_anchors, k, dx, dy;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            1: write_threshold('0);
            3: write_threshold(THR_RESET);
            5: write_threshold('1);
            default: begin
               if ($urandom_range(0, 1))
                  write_threshold(THR_WIDTH'($urandom_range(16'h4000, 16'hC000)));
               else
                  write_threshold(THR_WIDTH'($urandom));
            end
         endcase
         left = 80;
         while (left > 0) begin
            length    = $urandom_range(1, 30);
            n_anchors = $urandom_range(1, 4);
            for (k = 0; k < n_anchors; k++) anchors[k] = random_box(8000);
            for (k = 0; k < length; k++) begin
               if ($urandom_range(0, 7) == 0) begin
                  send_box(k == 0 || $urandom_range(0, 7) == 0, random_box(16'hFFFF));
               end else begin
                  b  = anchors[$urandom_range(0, n_anchors - 1)];
                  dx = int'($urandom_range(0, b.box_width / 2)) - int'(b.box_width / 4);
                  dy = int'($urandom_range(0, b.box_height / 2)) - int'(b.box_height / 4);
                  b.center_x   = clamp_coord(int'(b.center_x) + dx);
                  b.center_y   = clamp_coord(int'(b.center_y) + dy);
                  b.box_width  = clamp_coord(int'(b.box_width) * int'($urandom_range(75, 125)) / 100);
                  b.box_height = clamp_coord(int'(b.box_height) * int'($urandom_range(75, 125)) / 100);
                  if ($urandom_range(0, 9) == 0) b.class_id = CLASS_WIDTH'($urandom);
                  send_box(k == 0, b);
               end
            end
            left -= length;
         end
      end
   endtask

   // Small boxes scattered over the whole plane are nearly all kept, so the store fills up.
   task automatic test_store_overflow();
      box_type frame_boxes[$];
      box_type b;
      int round, k;
      for (round = 0; round < 2; round++) begin
         if (round == 0)
            write_threshold(THR_WIDTH'($urandom_range(16'h4000, 16'hC000)));
         else
            write_threshold(THR_WIDTH'($urandom));
         frame_boxes.delete();
         for (k = 0; k < 330; k++) begin
            if (k > 0 && $urandom_range(0, 9) == 0)
               b = frame_boxes[$urandom_range(0, frame_boxes.size() - 1)];
            else
               b = random_box(255);
            frame_boxes.insert(frame_boxes.size(), b);
            send_box(k == 0, b);
         end
      end
   endtask

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.start_frame   = 1'b0;
      req_bus.class_id      = '0;
      req_bus.center_x      = '0;
      req_bus.center_y      = '0;
      req_bus.box_width     = '0;
      req_bus.box_height    = '0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.iou_threshold = '0;
      kept_count            = 0;
      threshold_q           = THR_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_threshold();
      test_threshold_extremes();
      test_random_frames();
      test_store_overflow();
      wait_idle();

      $display("Judged %0d boxes over %0d frame starts: %0d kept, %0d suppressed,",
               boxes_judged, frame_starts, n_kept, n_suppressed);
      $display("%0d kept past a full store; threshold written %0d times, both extremes included.",
               n_overflow, thr_writes);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/gbs_pkg.sv
rtl/gbs_req_if.sv
rtl/gbs_ram.sv
rtl/gbs_iou.sv
rtl/greedy_box_suppression_top.sv
dv/tb_greedy_box_suppression_top.sv
